// ===== src/ppafr_pkg.sv =====
// shared types, constants and saturating add/subtract for the face reconstruction block
`default_nettype none
package ppafr_pkg;
	localparam int VALUE_WIDTH = 32;
	localparam int FRACTION_BITS = 16;
	localparam int PROD_WIDTH = 2 * VALUE_WIDTH + 2;
	localparam int DIV_STEPS = 2 * VALUE_WIDTH;
	localparam int DCNT_WIDTH = $clog2(DIV_STEPS);

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef logic [VALUE_WIDTH-1:0] uval_t;

	localparam val_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam val_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam val_t SIXTH = val_t'(((64'd1 << FRACTION_BITS) + 64'd3) / 64'd6);
	localparam val_t ONE = val_t'(64'd1 << FRACTION_BITS);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_DIFF = 3'd1;
	localparam logic [2:0] PH_SLOPE = 3'd2;
	localparam logic [2:0] PH_FACE = 3'd3;
	localparam logic [2:0] PH_MONO = 3'd4;
	localparam logic [2:0] PH_KSI = 3'd5;
	localparam logic [2:0] PH_FIN = 3'd6;

	localparam logic [1:0] FIX_NONE = 2'd0;
	localparam logic [1:0] FIX_LEFT = 2'd1;
	localparam logic [1:0] FIX_RIGHT = 2'd2;

	typedef struct packed {
		val_t cell_average;
		val_t face_velocity;
		uval_t cell_width;
		logic row_end;
	} in_t;

	typedef struct packed {
		val_t face_value;
		logic overflow;
		logic row_last_out;
	} out_t;

	typedef struct packed {
		logic sat;
		val_t val;
	} alu_t;

	function automatic alu_t sat_addsub(input val_t a, input val_t b, input logic sub);
		logic signed [VALUE_WIDTH:0] ax;
		logic signed [VALUE_WIDTH:0] bx;
		logic signed [VALUE_WIDTH:0] s;
		alu_t r;
		ax = {a[VALUE_WIDTH-1], a};
		bx = {b[VALUE_WIDTH-1], b};
		s = sub ? (ax - bx) : (ax + bx);
		if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
			r.sat = 1'b1;
			r.val = s[VALUE_WIDTH] ? VMIN : VMAX;
		end else begin
			r.sat = 1'b0;
			r.val = s[VALUE_WIDTH-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== src/ppa_face_reconstruction_core.sv =====
// piecewise parabolic face reconstruction on one shared adder, multiplier and divider
//
// usage: cells of an x row enter on in_valid/in_ready, one request per cell, with
// row_end on the last cell. time_step is written through cfg_write/cfg_data while idle.
// a cell that follows at least five earlier cells of its row yields one face value
// on out_valid/out_ready; the first five cells of a row yield none.
// a cell that gives no result leaves the core idle with in_ready high. a cell that gives a result
// holds in_ready low after it is accepted, through 5 difference steps,
// 20 slope steps, 15 face steps, 18 to 26 monotonicity steps, 67 steps for ksi
// (64 of them the one-bit-per-cycle restoring divider) and 9 final steps.
// the result sits in an output register, so the next cell is taken while it waits;
// a finished result waits in its last step only while the output register is full.
// reset clears the window, delays, row count, time_step and all control state.
`default_nettype none
module ppa_face_reconstruction_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ppafr_pkg::in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output ppafr_pkg::out_t out_data,
	input wire logic cfg_write,
	input wire ppafr_pkg::uval_t cfg_data
);
	localparam int W = ppafr_pkg::VALUE_WIDTH;
	localparam int F = ppafr_pkg::FRACTION_BITS;
	localparam int P = ppafr_pkg::PROD_WIDTH;
	localparam int DW = ppafr_pkg::DIV_STEPS;
	localparam int CW = ppafr_pkg::DCNT_WIDTH;

	ppafr_pkg::val_t win_q [6];
	ppafr_pkg::val_t vel_q [3];
	ppafr_pkg::uval_t wid_q [3];
	ppafr_pkg::uval_t dt_q;
	logic [2:0] cnt_q;
	logic end_q;
	logic [2:0] phase_q;
	logic [3:0] sub_q;
	logic [2:0] k_q;
	logic [CW-1:0] dcnt_q;
	ppafr_pkg::val_t dd_q [5];
	ppafr_pkg::val_t sl_q [4];
	ppafr_pkg::val_t e_q [3];
	ppafr_pkg::val_t ml_q [2];
	ppafr_pkg::val_t mr_q [2];
	ppafr_pkg::val_t ta_q, tb_q, tc_q, ksi_q;
	logic [1:0] fix_q;
	logic sat_q;
	logic signed [P-1:0] prod_q;
	logic [DW-1:0] div_q;
	logic [DW-1:0] quot_q;
	ppafr_pkg::uval_t rem_q;
	ppafr_pkg::out_t out_q;
	logic out_valid_q;

	ppafr_pkg::val_t alu_a, alu_b;
	logic alu_sub;
	ppafr_pkg::alu_t alu;
	logic flag_en, mflag_en;
	logic signed [W:0] ma, mb;
	ppafr_pkg::val_t msat;
	logic msat_flag;
	logic [2:0] kp1, kp2;
	ppafr_pkg::val_t dm, dp, qc, half, slope_min, oth;
	logic cond;
	logic pos;
	ppafr_pkg::val_t qq, upv, lv, rv;
	logic [W:0] remx;
	logic div_ge;
	logic [W:0] remd;
	logic sat_next;
	logic [W-1:0] vmag;
	logic accept;
	logic out_load;

	assign in_ready = (phase_q == ppafr_pkg::PH_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_load = (phase_q == ppafr_pkg::PH_FIN) && (sub_q == 4'd8)
			&& (!out_valid_q || out_ready);

	assign kp1 = k_q + 3'd1;
	assign kp2 = k_q + 3'd2;
	assign dm = dd_q[k_q];
	assign dp = dd_q[kp1];
	assign cond = (dm > 0 && dp > 0) || (dm < 0 && dp < 0);
	assign qc = win_q[kp2];
	assign half = alu.val >>> 1;
	assign slope_min = (alu.val < tc_q) ? alu.val : tc_q;
	assign oth = (fix_q == ppafr_pkg::FIX_LEFT) ? mr_q[k_q[0]] : ml_q[k_q[0]];
	assign pos = vel_q[2] > 0;
	assign qq = pos ? win_q[2] : win_q[3];
	assign upv = pos ? mr_q[0] : ml_q[1];
	assign lv = pos ? ml_q[0] : ml_q[1];
	assign rv = pos ? mr_q[0] : mr_q[1];
	assign vmag = vel_q[2][W-1] ? W'(-vel_q[2]) : W'(vel_q[2]);

	assign remx = {rem_q, div_q[DW-1]};
	assign div_ge = remx >= {1'b0, wid_q[2]};
	assign remd = remx - {1'b0, wid_q[2]};

	always_comb begin
		if (prod_q[P-1:F+W-1] == {(P-F-W+1){prod_q[F+W-1]}}) begin
			msat = prod_q[F+W-1:F];
			msat_flag = 1'b0;
		end else begin
			msat = prod_q[P-1] ? ppafr_pkg::VMIN : ppafr_pkg::VMAX;
			msat_flag = 1'b1;
		end
	end

	assign alu = ppafr_pkg::sat_addsub(alu_a, alu_b, alu_sub);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_sub = 1'b0;
		flag_en = 1'b0;
		mflag_en = 1'b0;
		ma = '0;
		mb = '0;
		case (phase_q)
			ppafr_pkg::PH_DIFF: begin
				alu_a = win_q[kp1];
				alu_b = win_q[k_q];
				alu_sub = 1'b1;
				flag_en = 1'b1;
			end
			ppafr_pkg::PH_SLOPE: begin
				flag_en = cond;
				case (sub_q)
					4'd0: begin
						alu_a = win_q[kp2];
						alu_b = win_q[k_q];
						alu_sub = 1'b1;
					end
					4'd1: begin
						alu_b = dm;
						alu_sub = 1'b1;
					end
					4'd3: begin
						alu_b = dp;
						alu_sub = 1'b1;
					end
					default: begin
						alu_a = tb_q;
						alu_b = tb_q;
					end
				endcase
			end
			ppafr_pkg::PH_FACE: begin
				case (sub_q)
					4'd0: begin
						alu_a = win_q[kp2];
						alu_b = win_q[kp1];
						alu_sub = 1'b1;
						flag_en = 1'b1;
					end
					4'd1: begin
						alu_a = win_q[kp1];
						alu_b = ta_q;
						flag_en = 1'b1;
					end
					4'd2: begin
						alu_a = sl_q[kp1[1:0]];
						alu_b = sl_q[k_q[1:0]];
						alu_sub = 1'b1;
						flag_en = 1'b1;
					end
					4'd3: begin
						ma = (W+1)'(ppafr_pkg::SIXTH);
						mb = {tb_q[W-1], tb_q};
					end
					default: begin
						alu_a = ta_q;
						alu_b = msat;
						alu_sub = 1'b1;
						flag_en = 1'b1;
						mflag_en = 1'b1;
					end
				endcase
			end
			ppafr_pkg::PH_MONO: begin
				flag_en = 1'b1;
				case (sub_q)
					4'd0: begin
						alu_a = e_q[kp1[1:0]];
						alu_b = qc;
						alu_sub = 1'b1;
					end
					4'd1: begin
						alu_a = qc;
						alu_b = ml_q[k_q[0]];
						alu_sub = 1'b1;
					end
					4'd2: begin
						alu_a = mr_q[k_q[0]];
						alu_b = ml_q[k_q[0]];
						alu_sub = 1'b1;
					end
					4'd3: begin
						alu_a = ml_q[k_q[0]];
						alu_b = mr_q[k_q[0]];
					end
					4'd4: begin
						alu_a = qc;
						alu_b = ta_q >>> 1;
						alu_sub = 1'b1;
					end
					4'd5: begin
						alu_a = ta_q;
						alu_b = ta_q;
					end
					4'd6: begin
						alu_a = tc_q;
						alu_b = ta_q;
					end
					4'd7: begin
						alu_a = tc_q;
						alu_b = tc_q;
					end
					4'd8: begin
						alu_b = tb_q;
						alu_sub = 1'b1;
					end
					4'd9: begin
						alu_a = qc;
						alu_b = qc;
					end
					4'd10: begin
						alu_a = ta_q;
						alu_b = qc;
					end
					4'd11: begin
						alu_a = oth;
						alu_b = oth;
					end
					default: begin
						alu_a = ta_q;
						alu_b = tc_q;
						alu_sub = 1'b1;
					end
				endcase
			end
			ppafr_pkg::PH_KSI: begin
				ma = {1'b0, vmag};
				mb = {1'b0, dt_q};
			end
			ppafr_pkg::PH_FIN: begin
				flag_en = 1'b1;
				case (sub_q)
					4'd0: begin
						alu_a = qq;
						alu_b = qq;
					end
					4'd1: begin
						alu_a = ta_q;
						alu_b = rv;
						alu_sub = 1'b1;
					end
					4'd2: begin
						alu_a = ta_q;
						alu_b = lv;
						alu_sub = 1'b1;
					end
					4'd3: begin
						alu_a = qq;
						alu_b = upv;
						alu_sub = 1'b1;
					end
					4'd4: begin
						ma = {ksi_q[W-1], ksi_q};
						mb = {tb_q[W-1], tb_q};
						alu_a = ppafr_pkg::ONE;
						alu_b = ksi_q;
						alu_sub = 1'b1;
					end
					4'd5: begin
						ma = {ksi_q[W-1], ksi_q};
						mb = {tc_q[W-1], tc_q};
						alu_a = upv;
						alu_b = msat;
						mflag_en = 1'b1;
					end
					4'd6: begin
						flag_en = 1'b0;
						mflag_en = 1'b1;
					end
					4'd7: begin
						flag_en = 1'b0;
						ma = {tc_q[W-1], tc_q};
						mb = {ta_q[W-1], ta_q};
					end
					default: begin
						// keep the product steady while the result waits
						ma = {tc_q[W-1], tc_q};
						mb = {ta_q[W-1], ta_q};
						alu_a = tb_q;
						alu_b = msat;
						mflag_en = 1'b1;
					end
				endcase
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign sat_next = sat_q | (flag_en & alu.sat) | (mflag_en & msat_flag);

	always_ff @(posedge clk) begin
		prod_q <= P'(ma * mb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				vel_q[i] <= '0;
				wid_q[i] <= '0;
			end
			dt_q <= '0;
			cnt_q <= '0;
			end_q <= 1'b0;
			phase_q <= ppafr_pkg::PH_IDLE;
			sub_q <= '0;
			k_q <= '0;
			dcnt_q <= '0;
			fix_q <= ppafr_pkg::FIX_NONE;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				dt_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (phase_q)
				ppafr_pkg::PH_IDLE: begin
					if (accept) begin
						for (int i = 0; i < 5; i++) win_q[i] <= win_q[i+1];
						win_q[5] <= in_data.cell_average;
						vel_q[2] <= vel_q[1];
						vel_q[1] <= vel_q[0];
						vel_q[0] <= in_data.face_velocity;
						wid_q[2] <= wid_q[1];
						wid_q[1] <= wid_q[0];
						wid_q[0] <= in_data.cell_width;
						end_q <= in_data.row_end;
						if (in_data.row_end) begin
							cnt_q <= '0;
						end else if (cnt_q < 3'd5) begin
							cnt_q <= cnt_q + 3'd1;
						end
						if (cnt_q >= 3'd5) begin
							phase_q <= ppafr_pkg::PH_DIFF;
							k_q <= '0;
							sub_q <= '0;
							sat_q <= 1'b0;
						end
					end
				end
				ppafr_pkg::PH_DIFF: begin
					sat_q <= sat_next;
					dd_q[k_q] <= alu.val;
					if (k_q == 3'd4) begin
						phase_q <= ppafr_pkg::PH_SLOPE;
						k_q <= '0;
					end else begin
						k_q <= kp1;
					end
				end
				ppafr_pkg::PH_SLOPE: begin
					sat_q <= sat_next;
					sub_q <= sub_q + 4'd1;
					case (sub_q)
						4'd0: begin
							ta_q <= half;
							tc_q <= (half < 0) ? -half : half;
						end
						4'd1: tb_q <= (dm < 0) ? alu.val : dm;
						4'd2: tc_q <= slope_min;
						4'd3: tb_q <= (dp < 0) ? alu.val : dp;
						default: begin
							sub_q <= '0;
							sl_q[k_q[1:0]] <= !cond ? '0 : ((ta_q < 0) ? -slope_min : slope_min);
							if (k_q == 3'd3) begin
								phase_q <= ppafr_pkg::PH_FACE;
								k_q <= '0;
							end else begin
								k_q <= kp1;
							end
						end
					endcase
				end
				ppafr_pkg::PH_FACE: begin
					sat_q <= sat_next;
					sub_q <= sub_q + 4'd1;
					case (sub_q)
						4'd0: ta_q <= half;
						4'd1: ta_q <= alu.val;
						4'd2: tb_q <= alu.val;
						4'd3: tb_q <= tb_q;
						default: begin
							sub_q <= '0;
							e_q[k_q[1:0]] <= alu.val;
							if (k_q == 3'd2) begin
								phase_q <= ppafr_pkg::PH_MONO;
								k_q <= '0;
							end else begin
								k_q <= kp1;
							end
						end
					endcase
				end
				ppafr_pkg::PH_MONO: begin
					sat_q <= sat_next;
					sub_q <= sub_q + 4'd1;
					case (sub_q)
						4'd0: begin
							ta_q <= alu.val;
							ml_q[k_q[0]] <= e_q[k_q[1:0]];
							mr_q[k_q[0]] <= e_q[kp1[1:0]];
						end
						4'd1: begin
							if ((ta_q > 0 && alu.val < 0) || (ta_q < 0 && alu.val > 0)) begin
								ml_q[k_q[0]] <= qc;
								mr_q[k_q[0]] <= qc;
							end
						end
						4'd2: tb_q <= alu.val;
						4'd3: ta_q <= alu.val;
						4'd4: ta_q <= alu.val;
						4'd5: tc_q <= alu.val;
						4'd6: tc_q <= alu.val;
						4'd7: tc_q <= alu.val;
						4'd8: begin
							if ((tb_q > 0 && tc_q > tb_q) || (tb_q < 0 && tc_q < tb_q)) begin
								fix_q <= ppafr_pkg::FIX_LEFT;
							end else if ((tb_q > 0 && tc_q < alu.val)
									|| (tb_q < 0 && tc_q > alu.val)) begin
								fix_q <= ppafr_pkg::FIX_RIGHT;
							end else begin
								sub_q <= '0;
								if (k_q == 3'd1) begin
									phase_q <= ppafr_pkg::PH_KSI;
									k_q <= '0;
								end else begin
									k_q <= kp1;
								end
							end
						end
						4'd9: ta_q <= alu.val;
						4'd10: ta_q <= alu.val;
						4'd11: tc_q <= alu.val;
						default: begin
							sub_q <= '0;
							if (fix_q == ppafr_pkg::FIX_LEFT) begin
								ml_q[k_q[0]] <= alu.val;
							end else begin
								mr_q[k_q[0]] <= alu.val;
							end
							if (k_q == 3'd1) begin
								phase_q <= ppafr_pkg::PH_KSI;
								k_q <= '0;
							end else begin
								k_q <= kp1;
							end
						end
					endcase
				end
				ppafr_pkg::PH_KSI: begin
					case (sub_q)
						4'd0: sub_q <= 4'd1;
						4'd1: begin
							div_q <= prod_q[DW-1:0];
							rem_q <= '0;
							quot_q <= '0;
							dcnt_q <= '0;
							sub_q <= 4'd2;
						end
						4'd2: begin
							rem_q <= div_ge ? remd[W-1:0] : remx[W-1:0];
							quot_q <= {quot_q[DW-2:0], div_ge};
							div_q <= {div_q[DW-2:0], 1'b0};
							dcnt_q <= dcnt_q + 1'b1;
							if (dcnt_q == CW'(DW - 1)) begin
								sub_q <= 4'd3;
							end
						end
						default: begin
							if (quot_q > DW'(ppafr_pkg::VMAX)) begin
								ksi_q <= ppafr_pkg::VMAX;
								sat_q <= 1'b1;
							end else begin
								ksi_q <= quot_q[W-1:0];
							end
							phase_q <= ppafr_pkg::PH_FIN;
							sub_q <= '0;
						end
					endcase
				end
				ppafr_pkg::PH_FIN: begin
					case (sub_q)
						4'd0: ta_q <= alu.val;
						4'd1: ta_q <= alu.val;
						4'd2: ta_q <= alu.val;
						4'd3: tb_q <= alu.val;
						4'd4: tc_q <= alu.val;
						4'd5: tb_q <= alu.val;
						4'd6: tc_q <= msat;
						4'd7: tc_q <= tc_q;
						default: begin
							if (out_load) begin
								out_q.face_value <= alu.val;
								out_q.overflow <= sat_next;
								out_q.row_last_out <= end_q;
								phase_q <= ppafr_pkg::PH_IDLE;
							end
						end
					endcase
					if (sub_q != 4'd8) begin
						sat_q <= sat_next;
						sub_q <= sub_q + 4'd1;
					end
				end
				default: phase_q <= ppafr_pkg::PH_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
